>>> rtl/core/wphe_pkg.sv
// ----------------------------------------------------------------------------
// wphe_pkg: shared types and constants for the waypoint heading error unit
// Field widths, CORDIC datapath widths, the arctangent table and the
// angle constants used by the datapath modules.
// ----------------------------------------------------------------------------
package wphe_pkg;

   // Request and response field widths
   localparam int LAT_W = 31;
   localparam int LON_W = 32;
   localparam int HDG_W = 16;
   localparam int ERR_W = 16;
   localparam int BRG_W = 16;

   // Differences are kept exactly, one bit wider than the operands
   localparam int DLAT_W = LAT_W + 1;
   localparam int DLON_W = LON_W + 1;

   // CORDIC datapath
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int CORDIC_STAGES_MAX = 32;
   localparam int PRE_SHIFT         = 24;
   localparam int ANG_FRAC          = 24;
   localparam int X_W               = 60;
   localparam int Z_W               = 33;

   // Angle to centidegree conversion
   localparam int ANG_MAG_W   = 31;
   localparam int CENTI_SCALE = 100;
   localparam int PROD_W      = 38;
   localparam int A_W         = PROD_W - ANG_FRAC;

   localparam logic signed [Z_W-1:0]    ANGLE_LIMIT = Z_W'(90) <<< ANG_FRAC;
   localparam logic [PROD_W-1:0]        ROUND_HALF  = PROD_W'(1) << (ANG_FRAC - 1);

   // Bearing and error arithmetic in centidegrees
   localparam int BRG_INT_W = 17;
   localparam int ERR_INT_W = 18;
   localparam logic [BRG_INT_W-1:0] HALF_TURN = 17'd18000;
   localparam logic [BRG_INT_W-1:0] FULL_TURN = 17'd36000;
   localparam logic [BRG_W-1:0]     BRG_MAX   = 16'd35999;
   localparam logic signed [ERR_INT_W-1:0] ERR_WRAP_HI = 18'sd18000;
   localparam logic signed [ERR_INT_W-1:0] ERR_WRAP_LO = -18'sd18000;
   localparam logic signed [ERR_INT_W-1:0] ERR_TURN    = 18'sd36000;

   // atan(2^-i) in units of 2^-24 degree
   localparam logic signed [Z_W-1:0] ATAN_TABLE [CORDIC_STAGES_MAX] = '{
      33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938,
      33'sd60000934,  33'sd30029717,  33'sd15018523,  33'sd7509720,
      33'sd3754917,   33'sd1877466,   33'sd938734,    33'sd469367,
      33'sd234684,    33'sd117342,    33'sd58671,     33'sd29335,
      33'sd14668,     33'sd7334,      33'sd3667,      33'sd1833,
      33'sd917,       33'sd458,       33'sd229,       33'sd115,
      33'sd57,        33'sd29,        33'sd14,        33'sd7,
      33'sd4,         33'sd2,         33'sd1,         33'sd0
   };

   // Quadrant of the (north, east) difference vector
   typedef enum logic [1:0] {
      QUAD_NE,   // north >= 0, east >= 0
      QUAD_SE,   // north <  0, east >= 0
      QUAD_SW,   // north <  0, east <  0
      QUAD_NW    // north >= 0, east <  0
   } wphe_quad_type;

   // Data travelling alongside the CORDIC vector
   typedef struct packed {
      wphe_quad_type    quad;
      logic             zero;
      logic [HDG_W-1:0] heading;
   } wphe_side_type;

   // One result as held in the output buffer
   typedef struct packed {
      logic signed [ERR_W-1:0] err;
      logic [BRG_W-1:0]        brg;
   } wphe_result_type;

endpackage

>>> rtl/core/wphe_if.sv
// ----------------------------------------------------------------------------
// wphe_if: request and response channel interfaces
// Valid/ready channels carrying the position request and the bearing result.
// ----------------------------------------------------------------------------
interface wphe_req_if;
   import wphe_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [LAT_W-1:0] cur_latitude;
   logic signed [LON_W-1:0] cur_longitude;
   logic signed [LAT_W-1:0] next_latitude;
   logic signed [LON_W-1:0] next_longitude;
   logic [HDG_W-1:0]        heading_centideg;

   modport source (output valid, cur_latitude, cur_longitude, next_latitude,
                   next_longitude, heading_centideg, input ready);
   modport sink   (input valid, cur_latitude, cur_longitude, next_latitude,
                   next_longitude, heading_centideg, output ready);
endinterface

interface wphe_rsp_if;
   import wphe_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [ERR_W-1:0] heading_error_centideg;
   logic [BRG_W-1:0]        bearing_centideg;

   modport source (output valid, heading_error_centideg, bearing_centideg,
                   input ready);
   modport sink   (input valid, heading_error_centideg, bearing_centideg,
                   output ready);
endinterface

>>> rtl/core/wphe_prep.sv
// ----------------------------------------------------------------------------
// wphe_prep: position differences and CORDIC start vector
// Two stages: exact differences, then magnitudes, quadrant and scaling.
// ----------------------------------------------------------------------------
module wphe_prep (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic signed [wphe_pkg::LAT_W-1:0] cur_latitude,
   input  logic signed [wphe_pkg::LON_W-1:0] cur_longitude,
   input  logic signed [wphe_pkg::LAT_W-1:0] next_latitude,
   input  logic signed [wphe_pkg::LON_W-1:0] next_longitude,
   input  logic [wphe_pkg::HDG_W-1:0]        heading_centideg,
   output logic                             out_valid,
   output logic signed [wphe_pkg::X_W-1:0]   out_x,
   output logic signed [wphe_pkg::X_W-1:0]   out_y,
   output wphe_pkg::wphe_side_type           out_side
);
   import wphe_pkg::*;

   logic                     valid0_ff;
   logic signed [DLAT_W-1:0] dlat_ff, dlat_in;
   logic signed [DLON_W-1:0] dlon_ff, dlon_in;
   logic [HDG_W-1:0]         heading0_ff;

   logic                     valid1_ff;
   logic signed [X_W-1:0]    x_ff, x_in;
   logic signed [X_W-1:0]    y_ff, y_in;
   wphe_side_type            side_ff, side_in;
   logic [DLAT_W-1:0]        mag_lat;
   logic [DLON_W-1:0]        mag_lon;

   always_comb begin
      dlat_in = DLAT_W'(next_latitude) - DLAT_W'(cur_latitude);
      dlon_in = DLON_W'(next_longitude) - DLON_W'(cur_longitude);
   end

   always_comb begin
      mag_lat = dlat_ff[DLAT_W-1] ? DLAT_W'(-dlat_ff) : DLAT_W'(dlat_ff);
      mag_lon = dlon_ff[DLON_W-1] ? DLON_W'(-dlon_ff) : DLON_W'(dlon_ff);
      x_in    = signed'(X_W'({mag_lat, {PRE_SHIFT{1'b0}}}));
      y_in    = signed'(X_W'({mag_lon, {PRE_SHIFT{1'b0}}}));
      if (dlat_ff[DLAT_W-1]) begin
         side_in.quad = dlon_ff[DLON_W-1] ? QUAD_SW : QUAD_SE;
      end else begin
         side_in.quad = dlon_ff[DLON_W-1] ? QUAD_NW : QUAD_NE;
      end
      side_in.zero    = (dlat_ff == '0) && (dlon_ff == '0);
      side_in.heading = heading0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
      end else if (advance) begin
         valid0_ff <= in_valid;
         valid1_ff <= valid0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dlat_ff     <= dlat_in;
         dlon_ff     <= dlon_in;
         heading0_ff <= heading_centideg;
         x_ff        <= x_in;
         y_ff        <= y_in;
         side_ff     <= side_in;
      end
   end

   assign out_valid = valid1_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_side  = side_ff;

endmodule

>>> rtl/core/wphe_cell.sv
// ----------------------------------------------------------------------------
// wphe_cell: one CORDIC vectoring rotation
// Rotates the vector towards the positive x axis by atan(2^-STAGE) and
// accumulates the angle, passing the result to the next cell.
// ----------------------------------------------------------------------------
module wphe_cell #(
   parameter int STAGE = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  logic signed [wphe_pkg::X_W-1:0] in_x,
   input  logic signed [wphe_pkg::X_W-1:0] in_y,
   input  logic signed [wphe_pkg::Z_W-1:0] in_z,
   input  wphe_pkg::wphe_side_type         in_side,
   output logic                            out_valid,
   output logic signed [wphe_pkg::X_W-1:0] out_x,
   output logic signed [wphe_pkg::X_W-1:0] out_y,
   output logic signed [wphe_pkg::Z_W-1:0] out_z,
   output wphe_pkg::wphe_side_type         out_side
);
   import wphe_pkg::*;

   logic                  valid_ff;
   logic signed [X_W-1:0] x_ff, x_in;
   logic signed [X_W-1:0] y_ff, y_in;
   logic signed [Z_W-1:0] z_ff, z_in;
   wphe_side_type         side_ff;
   logic signed [X_W-1:0] xs;
   logic signed [X_W-1:0] ys;

   always_comb begin
      // Arithmetic shifts round towards minus infinity
      xs = in_x >>> STAGE;
      ys = in_y >>> STAGE;
      if (!in_y[X_W-1]) begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + ATAN_TABLE[STAGE];
      end else begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - ATAN_TABLE[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

>>> rtl/core/wphe_post.sv
// ----------------------------------------------------------------------------
// wphe_post: angle to compass bearing and heading error
// Clamps and scales the CORDIC angle, places it in its quadrant and forms
// the wrapped heading error, over four stages.
// ----------------------------------------------------------------------------
module wphe_post (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic signed [wphe_pkg::Z_W-1:0]  in_z,
   input  wphe_pkg::wphe_side_type          in_side,
   output logic                             out_valid,
   output wphe_pkg::wphe_result_type        out_result
);
   import wphe_pkg::*;

   // Stage 1: clamp to a quarter turn and scale by one hundred
   logic                    v1_ff;
   logic [ANG_MAG_W-1:0]    zc;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   wphe_side_type           side1_ff;

   // Stage 2: round to centidegrees
   logic                    v2_ff;
   logic [PROD_W-1:0]       rnd;
   logic [A_W-1:0]          a_ff, a_in;
   wphe_side_type           side2_ff;

   // Stage 3: compass bearing
   logic                    v3_ff;
   logic [BRG_INT_W-1:0]    ext_a;
   logic [BRG_INT_W-1:0]    brg_raw;
   logic [BRG_W-1:0]        brg3_ff, brg3_in;
   logic [HDG_W-1:0]        heading3_ff;

   // Stage 4: heading error
   logic                    v4_ff;
   logic signed [ERR_INT_W-1:0] diff;
   logic signed [ERR_INT_W-1:0] wrapped;
   wphe_result_type         res_ff, res_in;

   always_comb begin
      if (in_z[Z_W-1]) begin
         zc = '0;
      end else if (in_z > ANGLE_LIMIT) begin
         zc = ANG_MAG_W'(ANGLE_LIMIT);
      end else begin
         zc = ANG_MAG_W'(in_z);
      end
      prod_in = PROD_W'(zc) * PROD_W'(CENTI_SCALE);
   end

   always_comb begin
      rnd  = prod_ff + ROUND_HALF;
      // Coincident positions give a bearing of north
      a_in = side1_ff.zero ? '0 : rnd[ANG_FRAC +: A_W];
   end

   always_comb begin
      ext_a = BRG_INT_W'(a_ff);
      case (side2_ff.quad)
         QUAD_NE: brg_raw = ext_a;
         QUAD_SE: brg_raw = HALF_TURN - ext_a;
         QUAD_SW: brg_raw = HALF_TURN + ext_a;
         QUAD_NW: brg_raw = FULL_TURN - ext_a;
         default: brg_raw = ext_a;
      endcase
      // A full turn after rounding reads as north
      if (brg_raw >= FULL_TURN) begin
         brg3_in = BRG_W'(brg_raw - FULL_TURN);
      end else begin
         brg3_in = BRG_W'(brg_raw);
      end
   end

   always_comb begin
      diff = signed'(ERR_INT_W'(brg3_ff) - ERR_INT_W'(heading3_ff));
      if (diff >= ERR_WRAP_HI) begin
         wrapped = diff - ERR_TURN;
      end else if (diff < ERR_WRAP_LO) begin
         wrapped = diff + ERR_TURN;
      end else begin
         wrapped = diff;
      end
      res_in.err = ERR_W'(wrapped);
      res_in.brg = brg3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff     <= prod_in;
         side1_ff    <= in_side;
         a_ff        <= a_in;
         side2_ff    <= side1_ff;
         brg3_ff     <= brg3_in;
         heading3_ff <= side2_ff.heading;
         res_ff      <= res_in;
      end
   end

   assign out_valid  = v4_ff;
   assign out_result = res_ff;

endmodule

>>> rtl/core/wphe_outbuf.sv
// ----------------------------------------------------------------------------
// wphe_outbuf: response register with skid stage
// Holds the presented response and catches one more while the sink stalls,
// so that the upstream ready comes straight from a register.
// ----------------------------------------------------------------------------
module wphe_outbuf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  wphe_pkg::wphe_result_type in_result,
   output logic                      in_ready,
   output logic                      out_valid,
   input  logic                      out_ready,
   output wphe_pkg::wphe_result_type out_result
);
   import wphe_pkg::*;

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   wphe_result_type out_ff, out_in;
   wphe_result_type skid_ff, skid_in;
   logic            push;

   always_comb begin
      push          = in_valid && !skid_valid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = in_result;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = in_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign in_ready   = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

>>> rtl/core/waypoint_heading_error_unit.sv
// ----------------------------------------------------------------------------
// waypoint_heading_error_unit: bearing to the next waypoint and steering error
// Forms the north and east differences between two positions, finds the
// compass bearing by a pipelined CORDIC vectoring arctangent and subtracts
// the vessel heading, wrapping the error once into a half turn either way.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   -------  ---------  ---------------------------------------------------
//   req_     in         current and next positions, vessel heading
//   rsp_     out        wrapped heading error and bearing, in centidegrees
//
// One request may be accepted in every cycle while req_chan.ready is high.
// Each response passes through two preparation stages, one cell per CORDIC
// rotation, four scaling and bearing stages and the response register.
// Reset is synchronous and clears only the valid flags. A stalled sink fills
// the response register and its skid stage; req_chan.ready then falls and
// the whole pipeline holds.
//
module waypoint_heading_error_unit #(
   parameter int CORDIC_STAGES = wphe_pkg::CORDIC_STAGES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   wphe_req_if.sink      req_chan,
   wphe_rsp_if.source    rsp_chan
);
   import wphe_pkg::*;

   // Common pipeline enable, taken from the skid stage's register
   logic                  advance;

   // Links of the cell chain: entry 0 is the start vector from preparation
   logic                  cell_valid [CORDIC_STAGES+1];
   logic signed [X_W-1:0] cell_x     [CORDIC_STAGES+1];
   logic signed [X_W-1:0] cell_y     [CORDIC_STAGES+1];
   logic signed [Z_W-1:0] cell_z     [CORDIC_STAGES+1];
   wphe_side_type         cell_side  [CORDIC_STAGES+1];

   logic                  post_valid;
   wphe_result_type       post_result;
   wphe_result_type       rsp_result;

   assign req_chan.ready = advance;

   // Differences, magnitudes and quadrant of the request
   wphe_prep u_prep (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .in_valid         (req_chan.valid),
      .cur_latitude     (req_chan.cur_latitude),
      .cur_longitude    (req_chan.cur_longitude),
      .next_latitude    (req_chan.next_latitude),
      .next_longitude   (req_chan.next_longitude),
      .heading_centideg (req_chan.heading_centideg),
      .out_valid        (cell_valid[0]),
      .out_x            (cell_x[0]),
      .out_y            (cell_y[0]),
      .out_side         (cell_side[0])
   );

   // The angle accumulator starts at zero for every request
   assign cell_z[0] = '0;

   // Row of CORDIC cells, one rotation each, every cell a pipeline stage
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      wphe_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cell_valid[g]),
         .in_x      (cell_x[g]),
         .in_y      (cell_y[g]),
         .in_z      (cell_z[g]),
         .in_side   (cell_side[g]),
         .out_valid (cell_valid[g+1]),
         .out_x     (cell_x[g+1]),
         .out_y     (cell_y[g+1]),
         .out_z     (cell_z[g+1]),
         .out_side  (cell_side[g+1])
      );
   end

   // Angle scaling, quadrant placement and heading error. The final x and y
   // of the chain are not needed: only the accumulated angle carries on.
   wphe_post u_post (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (cell_valid[CORDIC_STAGES]),
      .in_z       (cell_z[CORDIC_STAGES]),
      .in_side    (cell_side[CORDIC_STAGES]),
      .out_valid  (post_valid),
      .out_result (post_result)
   );

   // Response register and skid stage
   wphe_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (post_valid),
      .in_result  (post_result),
      .in_ready   (advance),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_result (rsp_result)
   );

   assign rsp_chan.heading_error_centideg = rsp_result.err;
   assign rsp_chan.bearing_centideg       = rsp_result.brg;

`ifndef ASSERT_OFF
   // The bearing is always folded back below a full turn
   a_bearing_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.bearing_centideg <= BRG_MAX))
      else $error("bearing of a response is a full turn or more");

   // Requests are refused only while a response is waiting at the output
   a_stall_has_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("request refused with no response presented");

   // A full skid stage cannot drain while the sink keeps stalling
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready && !req_chan.ready) |=> !req_chan.ready)
      else $error("skid stage emptied while the response was stalled");
`endif

endmodule
